/* sv/phrp_pkg.sv */
// ----------------------------------------------------------------------------
// Packed HSL palette converter package
// Shared widths, pipeline tag type and sequencer state encoding.
// ----------------------------------------------------------------------------
package phrp_pkg;

    localparam int CODE_W = 16;
    localparam int RGB_W  = 24;
    localparam int CH_W   = 8;
    localparam int DIST_W = 18;

    localparam logic [CODE_W-1:0] LAST_CODE = '1;

    localparam logic MODE_TO_RGB  = 1'b0;
    localparam logic MODE_TO_CODE = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

endpackage

/* sv/phrp_palette_gen.sv */
// ----------------------------------------------------------------------------
// Palette entry generator
// Two-stage pipeline that computes the 24-bit palette colour of a code.
// ----------------------------------------------------------------------------
module phrp_palette_gen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  phrp_pkg::t_tag               i_tag,
    input  logic [phrp_pkg::CODE_W-1:0]  i_code,
    output phrp_pkg::t_tag               o_tag,
    output logic [phrp_pkg::CODE_W-1:0] o_code,
    output logic [phrp_pkg::RGB_W-1:0]  o_rgb
);

    // Ramp weight of a channel phase: the channel value is 64P + (Q-P)*u.
    function automatic logic [6:0] ramp_of(input logic [8:0] t);
        logic [8:0] w;
        begin
            w = 9'd0;
            if (t < 9'd64) begin
                w = t;
            end else if (t < 9'd192) begin
                w = 9'd64;
            end else if (t < 9'd256) begin
                w = 9'd256 - t;
            end
            ramp_of = w[6:0];
        end
    endfunction

    logic [5:0]  hue;
    logic [3:0]  sat2;
    logic [6:0]  lum;
    logic [10:0] lum_sat;
    logic [11:0] q_wide;
    logic [11:0] p_wide;
    logic [10:0] q_val;
    logic [10:0] p_val;
    logic [8:0]  t_odd;
    logic [8:0]  t_g;
    logic [8:0]  t_r;
    logic [8:0]  t_b;

    phrp_pkg::t_tag              r_tag_a;
    logic [phrp_pkg::CODE_W-1:0] r_code_a;
    logic [10:0]                 r_p;
    logic [10:0]                 r_d;
    logic [6:0]                  r_u_r;
    logic [6:0]                  r_u_g;
    logic [6:0]                  r_u_b;

    logic [17:0] v_r;
    logic [17:0] v_g;
    logic [17:0] v_b;

    phrp_pkg::t_tag              r_tag_b;
    logic [phrp_pkg::CODE_W-1:0] r_code_b;
    logic [phrp_pkg::RGB_W-1:0]  r_rgb;

    always_comb begin
        hue     = i_code[15:10];
        sat2    = {i_code[9:7], 1'b1};
        lum     = i_code[6:0];
        lum_sat = {4'b0, lum} * {7'b0, sat2};
        if (lum[6]) begin
            q_wide = {1'b0, lum, 4'b0} + {1'b0, sat2, 7'b0} - {1'b0, lum_sat};
        end else begin
            q_wide = {1'b0, lum_sat} + {1'b0, lum, 4'b0};
        end
        q_val  = q_wide[10:0];
        p_wide = {lum, 5'b0} - {1'b0, q_val};
        p_val  = p_wide[10:0];
        t_odd  = {2'b0, hue, 1'b1};
        t_g    = t_odd + {t_odd[7:0], 1'b0};
        if (t_g + 9'd128 > 9'd384) begin
            t_r = t_g + 9'd128 - 9'd384;
        end else begin
            t_r = t_g + 9'd128;
        end
        if (t_g >= 9'd128) begin
            t_b = t_g - 9'd128;
        end else begin
            t_b = t_g + 9'd256;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code_a <= i_code;
        r_p      <= p_val;
        r_d      <= q_val - p_val;
        r_u_r    <= ramp_of(t_r);
        r_u_g    <= ramp_of(t_g);
        r_u_b    <= ramp_of(t_b);
    end

    always_comb begin
        v_r = {1'b0, r_p, 6'b0} + ({7'b0, r_d} * {11'b0, r_u_r});
        v_g = {1'b0, r_p, 6'b0} + ({7'b0, r_d} * {11'b0, r_u_g});
        v_b = {1'b0, r_p, 6'b0} + ({7'b0, r_d} * {11'b0, r_u_b});
    end

    always_ff @(posedge i_clk) begin
        r_code_b <= r_code_a;
        r_rgb    <= {v_r[16:9], v_g[16:9], v_b[16:9]};
    end

    assign o_tag  = r_tag_b;
    assign o_code = r_code_b;
    assign o_rgb  = r_rgb;

endmodule

/* sv/phrp_nearest.sv */
// ----------------------------------------------------------------------------
// Nearest colour tracker
// Squared RGB distance stage followed by the best and exact match registers.
// ----------------------------------------------------------------------------
module phrp_nearest (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic [phrp_pkg::RGB_W-1:0]   i_target,
    input  phrp_pkg::t_tag               i_tag,
    input  logic [phrp_pkg::CODE_W-1:0]  i_code,
    input  logic [phrp_pkg::RGB_W-1:0]   i_rgb,
    output logic                         o_done,
    output logic [phrp_pkg::CODE_W-1:0] o_code
);

    function automatic logic [phrp_pkg::CH_W-1:0] abs_diff(
        input logic [phrp_pkg::CH_W-1:0] a,
        input logic [phrp_pkg::CH_W-1:0] b
    );
        begin
            abs_diff = (a >= b) ? a - b : b - a;
        end
    endfunction

    logic [phrp_pkg::CH_W-1:0]   dr;
    logic [phrp_pkg::CH_W-1:0]   dg;
    logic [phrp_pkg::CH_W-1:0]   db;
    logic [phrp_pkg::DIST_W-1:0] sq_dist;

    phrp_pkg::t_tag              r_tag;
    logic [phrp_pkg::CODE_W-1:0] r_code;
    logic [phrp_pkg::DIST_W-1:0] r_dist;

    logic [phrp_pkg::DIST_W-1:0] r_best_dist;
    logic [phrp_pkg::CODE_W-1:0] r_best_code;
    logic [phrp_pkg::CODE_W-1:0] r_exact_code;
    logic                        r_exact_seen;
    logic                        r_done;

    always_comb begin
        dr      = abs_diff(i_target[23:16], i_rgb[23:16]);
        dg      = abs_diff(i_target[15:8], i_rgb[15:8]);
        db      = abs_diff(i_target[7:0], i_rgb[7:0]);
        sq_dist = ({10'b0, dr} * {10'b0, dr}) + ({10'b0, dg} * {10'b0, dg})
                + ({10'b0, db} * {10'b0, db});
    end

    always_ff @(posedge i_clk) begin
        r_code <= i_code;
        r_dist <= sq_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag        <= '0;
            r_done       <= 1'b0;
            r_best_dist  <= '1;
            r_best_code  <= '0;
            r_exact_code <= '0;
            r_exact_seen <= 1'b0;
        end else begin
            r_tag  <= i_tag;
            r_done <= r_tag.valid && r_tag.last;
            if (i_clear) begin
                r_best_dist  <= '1;
                r_best_code  <= '0;
                r_exact_code <= '0;
                r_exact_seen <= 1'b0;
            end else if (r_tag.valid) begin
                if (r_dist < r_best_dist) begin
                    r_best_dist <= r_dist;
                    r_best_code <= r_code;
                end
                if (r_dist == '0) begin
                    r_exact_code <= r_code;
                    r_exact_seen <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_code = r_exact_seen ? r_exact_code : r_best_code;

endmodule

/* sv/packed_hsl_rgb_palette_converter.sv */
// ----------------------------------------------------------------------------
// Packed HSL to RGB palette converter
// Converts a packed 16-bit HSL code to its palette colour, or finds the
// palette code that matches or lies nearest to a 24-bit RGB colour.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// request   in         start and !busy    i_mode, i_hsl_code, i_rgb_in
// result    out        o_valid, 1 cycle   o_rgb_out, o_code_out
//
// A forward request passes the issue state and both palette generator
// stages, and its result is registered onto the strobe. A reverse request
// issues all 65536 codes, one entry per cycle, then drains the pipeline.
// Reset is synchronous and active low; the block is idle right after it.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module packed_hsl_rgb_palette_converter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic [phrp_pkg::CODE_W-1:0]  i_hsl_code,
    input  logic [phrp_pkg::RGB_W-1:0]   i_rgb_in,
    output logic                         o_valid,
    output logic [phrp_pkg::RGB_W-1:0]  o_rgb_out,
    output logic [phrp_pkg::CODE_W-1:0] o_code_out
);

    phrp_pkg::t_state            r_state;
    phrp_pkg::t_state            n_state;
    logic                        r_mode;
    logic [phrp_pkg::CODE_W-1:0] r_code;
    logic [phrp_pkg::RGB_W-1:0]  r_target;
    logic [phrp_pkg::CODE_W-1:0] r_idx;
    logic [phrp_pkg::CODE_W-1:0] n_idx;
    logic                        r_valid;
    logic                        n_valid;
    logic [phrp_pkg::RGB_W-1:0]  r_rgb_out;
    logic [phrp_pkg::RGB_W-1:0]  n_rgb_out;
    logic [phrp_pkg::CODE_W-1:0] r_code_out;
    logic [phrp_pkg::CODE_W-1:0] n_code_out;

    logic                        accept;
    phrp_pkg::t_tag              issue_tag;
    logic [phrp_pkg::CODE_W-1:0] issue_code;
    phrp_pkg::t_tag              gen_tag;
    logic [phrp_pkg::CODE_W-1:0] gen_code;
    logic [phrp_pkg::RGB_W-1:0]  gen_rgb;
    phrp_pkg::t_tag              near_tag;
    logic                        near_done;
    logic [phrp_pkg::CODE_W-1:0] near_code;

    assign accept = start && !busy;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_valid    = 1'b0;
        n_rgb_out  = r_rgb_out;
        n_code_out = r_code_out;
        issue_tag  = '0;
        issue_code = (r_mode == phrp_pkg::MODE_TO_CODE) ? r_idx : r_code;
        case (r_state)
            phrp_pkg::S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_state = phrp_pkg::S_ISSUE;
                end
            end
            phrp_pkg::S_ISSUE: begin
                issue_tag.valid = 1'b1;
                issue_tag.last  = (r_mode == phrp_pkg::MODE_TO_RGB)
                                || (r_idx == phrp_pkg::LAST_CODE);
                n_idx           = r_idx + phrp_pkg::CODE_W'(1);
                if (issue_tag.last) begin
                    n_state = phrp_pkg::S_DRAIN;
                end
            end
            phrp_pkg::S_DRAIN: begin
                if ((r_mode == phrp_pkg::MODE_TO_RGB) && gen_tag.valid) begin
                    n_valid    = 1'b1;
                    n_rgb_out  = gen_rgb;
                    n_code_out = '0;
                    n_state    = phrp_pkg::S_IDLE;
                end else if ((r_mode == phrp_pkg::MODE_TO_CODE) && near_done) begin
                    n_valid    = 1'b1;
                    n_rgb_out  = '0;
                    n_code_out = near_code;
                    n_state    = phrp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = phrp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phrp_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_code   <= i_hsl_code;
            r_target <= i_rgb_in;
        end
        r_rgb_out  <= n_rgb_out;
        r_code_out <= n_code_out;
    end

    phrp_palette_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (issue_tag),
        .i_code  (issue_code),
        .o_tag   (gen_tag),
        .o_code  (gen_code),
        .o_rgb   (gen_rgb)
    );

    always_comb begin
        near_tag       = gen_tag;
        near_tag.valid = gen_tag.valid && (r_mode == phrp_pkg::MODE_TO_CODE);
    end

    phrp_nearest u_near (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept),
        .i_target (r_target),
        .i_tag    (near_tag),
        .i_code   (gen_code),
        .i_rgb    (gen_rgb),
        .o_done   (near_done),
        .o_code   (near_code)
    );

    assign busy       = (r_state != phrp_pkg::S_IDLE);
    assign o_valid    = r_valid;
    assign o_rgb_out  = r_rgb_out;
    assign o_code_out = r_code_out;

endmodule

/* sv/phrp_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the request and result ports of the palette converter.
// ----------------------------------------------------------------------------
module phrp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [phrp_pkg::RGB_W-1:0]   o_rgb_out,
    input logic [phrp_pkg::CODE_W-1:0]  o_code_out
);

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_busy_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("request finished without a result");

    a_one_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_rgb_out == '0) || (o_code_out == '0)))
        else $error("both result fields nonzero");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind packed_hsl_rgb_palette_converter phrp_checker u_phrp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_rgb_out  (o_rgb_out),
    .o_code_out (o_code_out)
);

/* verif/tb_packed_hsl_rgb_palette_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed HSL palette converter testbench
// Drives forward lookups and reverse palette searches, and predicts every
// result from an independently computed copy of the palette. Each result is
// checked against the oldest pending prediction, under varying request gaps.
// ----------------------------------------------------------------------------
module tb_packed_hsl_rgb_palette_converter;

    localparam int CODE_W         = phrp_pkg::CODE_W;
    localparam int RGB_W          = phrp_pkg::RGB_W;
    localparam int PALETTE_SIZE   = 65536;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 100;
    localparam int MAX_RANDOM_REV = 6;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        logic              mode;
        logic [CODE_W-1:0] code;
        logic [RGB_W-1:0]  rgb;
        int                gap_pct;
        bit                drain_first;
    } t_conv_request;

    typedef struct {
        logic [RGB_W-1:0]  rgb;
        logic [CODE_W-1:0] code;
    } t_conv_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_mode;
    logic [CODE_W-1:0] i_hsl_code;
    logic [RGB_W-1:0]  i_rgb_in;
    logic              o_valid;
    logic [RGB_W-1:0]  o_rgb_out;
    logic [CODE_W-1:0] o_code_out;

    logic [RGB_W-1:0] palette [PALETTE_SIZE];
    t_conv_request    request_queue[$];
    t_conv_result     awaited_conversions[$];
    bit               request_taken;
    int               fail_count;
    int               search_count;
    longint           cycle_count;
    longint           cycle_limit;

    packed_hsl_rgb_palette_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_mode     (i_mode),
        .i_hsl_code (i_hsl_code),
        .i_rgb_in   (i_rgb_in),
        .o_valid    (o_valid),
        .o_rgb_out  (o_rgb_out),
        .o_code_out (o_code_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int channel_level(int t, int p, int q);
        int v;
        if (t < 64) begin
            v = 64 * p + (q - p) * t;
        end else if (t < 192) begin
            v = 64 * q;
        end else if (t < 256) begin
            v = 64 * p + (q - p) * (256 - t);
        end else begin
            v = 64 * p;
        end
        if (v < 0) begin
            v = 0;
        end
        return (v / 512) & 'hff;
    endfunction

    function automatic logic [RGB_W-1:0] palette_color(int code);
        int hue;
        int sat2;
        int lum;
        int q;
        int p;
        int t_r;
        int t_g;
        int t_b;
        hue  = (code >> 10) & 'h3f;
        sat2 = 2 * ((code >> 7) & 'h7) + 1;
        lum  = code & 'h7f;
        if (lum >= 64) begin
            q = 16 * lum + 128 * sat2 - lum * sat2;
        end else begin
            q = lum * (sat2 + 16);
        end
        p = 32 * lum - q;
        t_g = 3 * (2 * hue + 1);
        t_r = t_g + 128;
        if (t_r > 384) begin
            t_r -= 384;
        end
        t_b = t_g - 128;
        if (t_b < 0) begin
            t_b += 384;
        end
        return {8'(channel_level(t_r, p, q)), 8'(channel_level(t_g, p, q)),
                8'(channel_level(t_b, p, q))};
    endfunction

    // The highest exact match wins; otherwise the lowest code at minimum distance.
    function automatic logic [CODE_W-1:0] nearest_code(logic [RGB_W-1:0] target);
        int idx;
        int dr;
        int dg;
        int db;
        int sq_dist;
        int best_dist;
        int best;
        int exact;
        bit exact_hit;
        best_dist = 'h3ffff;
        best = 0;
        exact = 0;
        exact_hit = 1'b0;
        for (idx = 0; idx < PALETTE_SIZE; idx++) begin
            dr = int'(target[23:16]) - int'(palette[idx][23:16]);
            dg = int'(target[15:8]) - int'(palette[idx][15:8]);
            db = int'(target[7:0]) - int'(palette[idx][7:0]);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best_dist) begin
                best_dist = sq_dist;
                best = idx;
            end
            if (sq_dist == 0) begin
                exact = idx;
                exact_hit = 1'b1;
            end
        end
        return exact_hit ? CODE_W'(exact) : CODE_W'(best);
    endfunction

    function automatic t_conv_result predict_conversion(logic mode, logic [CODE_W-1:0] code,
                                                        logic [RGB_W-1:0] rgb);
        t_conv_result res;
        if (mode == phrp_pkg::MODE_TO_RGB) begin
            res.rgb  = palette[code];
            res.code = '0;
        end else begin
            res.rgb  = '0;
            res.code = nearest_code(rgb);
        end
        return res;
    endfunction

    task automatic add_request(logic mode, logic [CODE_W-1:0] code, logic [RGB_W-1:0] rgb);
        t_conv_request req;
        req.mode = mode;
        req.code = code;
        req.rgb = rgb;
        req.gap_pct = 0;
        req.drain_first = 1'b0;
        request_queue.push_back(req);
        if (mode == phrp_pkg::MODE_TO_CODE) begin
            search_count++;
        end
    endtask

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", what);
        end
    endtask

    always @(negedge i_clk) begin
        t_conv_request head;
        logic next_start;
        if (i_rst_n) begin
            next_start = start;
            if (request_taken || !start) begin
                request_taken = 1'b0;
                next_start = 1'b0;
                if (request_queue.size() > 0) begin
                    head = request_queue[0];
                    if (!(head.drain_first && awaited_conversions.size() != 0) &&
                        $urandom_range(0, 99) >= head.gap_pct) begin
                        void'(request_queue.pop_front());
                        i_mode     <= head.mode;
                        i_hsl_code <= head.code;
                        i_rgb_in   <= head.rgb;
                        next_start = 1'b1;
                    end
                end
            end
            start <= next_start;
        end
    end

    always @(posedge i_clk) begin
        t_conv_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (awaited_conversions.size() == 0) begin
                    note_failure($sformatf("Result with no request pending: rgb %06h code %04h",
                                           o_rgb_out, o_code_out));
                end else begin
                    want = awaited_conversions.pop_front();
                    if (o_rgb_out !== want.rgb || o_code_out !== want.code) begin
                        note_failure($sformatf(
                            "Mismatch: expected rgb %06h code %04h, got rgb %06h code %04h",
                            want.rgb, want.code, o_rgb_out, o_code_out));
                    end
                end
            end
            if (start && !busy) begin
                awaited_conversions.push_back(predict_conversion(i_mode, i_hsl_code, i_rgb_in));
                request_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("packed_hsl_rgb_palette_converter verification failed");
            $finish;
        end
    end

    initial begin
        int idx;
        int total;
        int random_searches;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = phrp_pkg::MODE_TO_RGB;
        i_hsl_code = '0;
        i_rgb_in = '0;
        request_taken = 1'b0;
        fail_count = 0;
        search_count = 0;
        random_searches = 0;
        cycle_count = 0;
        cycle_limit = 64'd100_000_000;

        for (idx = 0; idx < PALETTE_SIZE; idx++) begin
            palette[idx] = palette_color(idx);
        end

        add_request(phrp_pkg::MODE_TO_RGB, 16'h0000, 24'h000000);
        add_request(phrp_pkg::MODE_TO_RGB, 16'hFFFF, 24'hFFFFFF);
        add_request(phrp_pkg::MODE_TO_RGB, 16'h007F, 24'h000000);
        add_request(phrp_pkg::MODE_TO_RGB, 16'hFC00, 24'hFFFFFF);
        add_request(phrp_pkg::MODE_TO_RGB, 16'h0380, 24'h000000);
        add_request(phrp_pkg::MODE_TO_RGB, 16'h03FF, 24'hFFFFFF);
        add_request(phrp_pkg::MODE_TO_RGB, 16'hFC7F, 24'h000000);
        add_request(phrp_pkg::MODE_TO_RGB, 16'h8040, 24'hFFFFFF);
        add_request(phrp_pkg::MODE_TO_RGB, 16'h5555, 24'hAAAAAA);
        add_request(phrp_pkg::MODE_TO_RGB, 16'hAAAA, 24'h555555);
        add_request(phrp_pkg::MODE_TO_RGB, 16'hAC3F, 24'h123456);
        // Black matches many codes exactly, so the highest of them must win.
        add_request(phrp_pkg::MODE_TO_CODE, 16'hFFFF, 24'h000000);
        // Pure white and mid grey have no exact entry and exercise distance ties.
        add_request(phrp_pkg::MODE_TO_CODE, 16'h0000, 24'hFFFFFF);
        add_request(phrp_pkg::MODE_TO_CODE, 16'hFFFF, 24'h808080);
        add_request(phrp_pkg::MODE_TO_CODE, 16'h0000, palette[16'h5A3C]);

        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            if (random_searches < MAX_RANDOM_REV && $urandom_range(0, 15) == 0) begin
                random_searches++;
                if ($urandom_range(0, 3) != 0) begin
                    add_request(phrp_pkg::MODE_TO_CODE, 16'($urandom),
                                palette[$urandom_range(0, PALETTE_SIZE - 1)]);
                end else begin
                    add_request(phrp_pkg::MODE_TO_CODE, 16'($urandom), 24'($urandom));
                end
            end else begin
                add_request(phrp_pkg::MODE_TO_RGB, 16'($urandom), 24'($urandom));
            end
        end

        total = request_queue.size();
        for (idx = 0; idx < total; idx++) begin
            case ((idx * 4) / total)
                1: begin
                    request_queue[idx].gap_pct = 55;
                end
                3: begin
                    request_queue[idx].gap_pct = 26;
                end
                default: begin
                    request_queue[idx].gap_pct = 0;
                end
            endcase
        end
        request_queue[total - RANDOM_ITEMS].drain_first = 1'b1;
        request_queue[total - RANDOM_ITEMS / 2].drain_first = 1'b1;
        cycle_limit = 4 * (longint'(search_count) * 65600 + longint'(total) * 200) + 20000;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        do begin
            @(posedge i_clk);
        end while (request_queue.size() != 0 || start || awaited_conversions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && awaited_conversions.size() == 0) begin
            $display("packed_hsl_rgb_palette_converter verification clean");
        end else begin
            $display("packed_hsl_rgb_palette_converter verification failed");
        end
        $finish;
    end

endmodule
